@@ hdl/mmps_pkg.sv @@
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types and constants for the max-min point subset selector.
// ----------------------------------------------------------------------------
package mmps_pkg;

    localparam int DEF_MAX_POINTS  = 256;
    localparam int DEF_MAX_SELECT  = 64;
    localparam int DEF_COORD_WIDTH = 16;

    localparam int DIST_W      = 64;
    localparam int SEL_COUNT_W = 7;
    localparam int INDEX_OUT_W = 8;

    localparam logic [SEL_COUNT_W-1:0] SEL_COUNT_RST = 7'd8;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_PASS_I,
        S_I_PT,
        S_I_REF,
        S_N_CH,
        S_N_PT,
        S_N_DIST,
        S_N_WAIT,
        S_K_RD,
        S_K_PT,
        S_K_REF,
        S_SWAP,
        S_SEL_INIT,
        S_SC_RD,
        S_SC_CMP,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    // what the nearest-distance scan is computing for
    typedef enum logic [1:0] {
        PH_BEST,
        PH_CAND,
        PH_NN
    } phase_t;

endpackage

@@ hdl/max_min_point_subset_select.sv @@
// ----------------------------------------------------------------------------
// max_min_point_subset_select
// Picks select_count of the loaded 3-D points with a large minimum spacing.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one point per transaction, coordinates in s_tdata, s_tlast
//   marks the last point of the set. Points load one per cycle into the point
//   memory; points beyond MAX_POINTS are dropped.
//   After the last point the selection runs with s_tready low. Each squared
//   distance takes a chosen-list read, a point read, a distance start and a
//   wait on the distance unit. A swap pass runs over the n chosen points and
//   the m outside points; passes repeat until one makes no swap, then a final
//   nearest-distance sweep and a sorted readout of the chosen indices follow.
//   m_ channel: one transaction per chosen index in m_tdata, best spaced
//   first, m_tlast on the final one. If select_count is out of range a single
//   transaction with m_tuser high, m_tlast high and index 0 is sent.
//   A result is held in the output register until m_tready; a stalled
//   receiver just freezes the readout.
//   cfg_wr_en writes select_count at once; write it only while idle.
//   Reset (aresetn low, synchronous) empties the point set and restores
//   select_count to 8. No memory clearing is needed.
// ----------------------------------------------------------------------------
module max_min_point_subset_select #(
    parameter int MAX_POINTS  = mmps_pkg::DEF_MAX_POINTS,
    parameter int MAX_SELECT  = mmps_pkg::DEF_MAX_SELECT,
    parameter int COORD_WIDTH = mmps_pkg::DEF_COORD_WIDTH
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // configuration
    input  logic                                        cfg_wr_en,
    input  logic [mmps_pkg::SEL_COUNT_W-1:0]            cfg_wr_data,  // select_count
    // input points
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,  // coord_l, coord_a, coord_b
    input  logic                                        s_tlast,  // final_point
    // chosen indices
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [mmps_pkg::INDEX_OUT_W-1:0]            m_tdata,  // point_index
    output logic                                        m_tlast,  // last_result
    output logic                                        m_tuser   // error_flag
);
    import mmps_pkg::*;

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SW   = $clog2(MAX_SELECT + 1);
    localparam int SIW  = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
    localparam int PW   = 3 * COORD_WIDTH;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [SEL_COUNT_W-1:0] sel_cnt_reg, sel_cnt_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] total_reg, total_next;
    logic [CNTW-1:0] outn_reg, outn_next;
    logic [CNTW-1:0] c_reg, c_next;
    logic [CNTW-1:0] k_reg, k_next;
    logic [CNTW-1:0] pick_k_reg, pick_k_next;
    logic [SW-1:0]   n_reg, n_next;
    logic [SW-1:0]   i_reg, i_next;
    logic [SW-1:0]   j_reg, j_next;
    logic [SW-1:0]   e_reg, e_next;
    logic [SW-1:0]   bj_reg, bj_next;
    logic [IW-1:0]   p_reg, p_next;
    logic [IW-1:0]   q_reg, q_next;
    logic [IW-1:0]   pick_v_reg, pick_v_next;
    logic [PW-1:0]   ref_reg, ref_next;
    logic [DIST_W-1:0] min_reg, min_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [DIST_W-1:0] bmax_reg, bmax_next;
    logic found_reg, found_next;
    logic changed_reg, changed_next;
    logic fin_reg, fin_next;
    logic have_reg, have_next;
    logic [MAX_SELECT-1:0] emitted_reg, emitted_next;
    logic [INDEX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic out_last_reg, out_last_next;
    logic out_err_reg, out_err_next;
    logic out_valid_reg, out_valid_next;

    // memory ports
    logic            pts_we;
    logic [IW-1:0]   pts_waddr, pts_raddr;
    logic [PW-1:0]   pts_wdata, pts_rdata;
    logic            ch_we;
    logic [SIW-1:0]  ch_waddr, ch_raddr;
    logic [IW-1:0]   ch_wdata, ch_rdata;
    logic            os_we;
    logic [IW-1:0]   os_waddr, os_raddr;
    logic [IW-1:0]   os_wdata, os_rdata;
    logic            nn_we;
    logic [SIW-1:0]  nn_waddr, nn_raddr;
    logic [DIST_W-1:0] nn_wdata, nn_rdata;

    logic              sq_start;
    logic              sq_done;
    logic [DIST_W-1:0] sq_dist;

    logic            s_acc;
    logic            bad;
    logic [CNTW-1:0] total_new;
    logic [CNTW-1:0] c_ofs;
    logic [SW-1:0]   n_m1;

    mmps_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
        .aclk(aclk), .we(pts_we), .waddr(pts_waddr), .wdata(pts_wdata),
        .raddr(pts_raddr), .rdata(pts_rdata)
    );

    mmps_ram #(.WIDTH(IW), .DEPTH(MAX_SELECT)) u_chosen (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );

    mmps_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_outside (
        .aclk(aclk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
        .raddr(os_raddr), .rdata(os_rdata)
    );

    mmps_ram #(.WIDTH(DIST_W), .DEPTH(MAX_SELECT)) u_nn (
        .aclk(aclk), .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
        .raddr(nn_raddr), .rdata(nn_rdata)
    );

    mmps_sqdist #(.COORD_WIDTH(COORD_WIDTH)) u_sqdist (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .pa(ref_reg), .pb(pts_rdata), .done(sq_done), .dist_out(sq_dist)
    );

    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_idx_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // a full store keeps its count; the dropped point may still end the set
    assign total_new = (int'(cnt_reg) < MAX_POINTS) ? cnt_reg + CNTW'(1) : cnt_reg;
    assign bad = (sel_cnt_reg == '0) || (int'(sel_cnt_reg) > MAX_SELECT)
              || (int'(sel_cnt_reg) > int'(total_new));
    assign c_ofs = c_reg - CNTW'(n_reg);
    assign n_m1  = n_reg - SW'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_acc && s_tlast) begin
                    state_next = bad ? S_OUT_WAIT : S_INIT;
                end
            end
            S_INIT: begin
                if (c_reg == total_reg) begin
                    state_next = S_PASS_I;
                end
            end
            S_PASS_I: state_next = S_I_PT;
            S_I_PT:   state_next = S_I_REF;
            S_I_REF:  state_next = S_N_CH;
            S_N_CH: begin
                if (j_reg == n_reg) begin
                    case (phase_reg)
                        PH_BEST: state_next = S_K_RD;
                        PH_CAND: state_next = S_K_RD;
                        PH_NN:   state_next = (i_reg == n_m1) ? S_SEL_INIT : S_PASS_I;
                        default: state_next = S_K_RD;
                    endcase
                end else if (j_reg != i_reg) begin
                    state_next = S_N_PT;
                end
            end
            S_N_PT:   state_next = S_N_DIST;
            S_N_DIST: state_next = S_N_WAIT;
            S_N_WAIT: begin
                if (sq_done) begin
                    state_next = S_N_CH;
                end
            end
            S_K_RD:     state_next = (k_reg == outn_reg) ? S_SWAP : S_K_PT;
            S_K_PT:     state_next = S_K_REF;
            S_K_REF:    state_next = S_N_CH;
            S_SWAP:     state_next = S_PASS_I;
            S_SEL_INIT: state_next = S_SC_RD;
            S_SC_RD:    state_next = (j_reg == n_reg) ? S_OUT_RD : S_SC_CMP;
            S_SC_CMP:   state_next = S_SC_RD;
            S_OUT_RD:   state_next = S_OUT_LD;
            S_OUT_LD:   state_next = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (m_tready) begin
                    state_next = out_last_reg ? S_LOAD : S_SEL_INIT;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        sel_cnt_next   = cfg_wr_en ? cfg_wr_data : sel_cnt_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        outn_next      = outn_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        pick_k_next    = pick_k_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        bj_next        = bj_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        pick_v_next    = pick_v_reg;
        ref_next       = ref_reg;
        min_next       = min_reg;
        best_next      = best_reg;
        bmax_next      = bmax_reg;
        found_next     = found_reg;
        changed_next   = changed_reg;
        fin_next       = fin_reg;
        have_next      = have_reg;
        emitted_next   = emitted_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg;

        pts_we    = 1'b0;
        pts_waddr = IW'(cnt_reg);
        pts_wdata = s_tdata[PW-1:0];
        pts_raddr = ch_rdata;
        ch_we     = 1'b0;
        ch_waddr  = SIW'(i_reg);
        ch_wdata  = pick_v_reg;
        ch_raddr  = SIW'(j_reg);
        os_we     = 1'b0;
        os_waddr  = IW'(pick_k_reg);
        os_wdata  = p_reg;
        os_raddr  = IW'(k_reg);
        nn_we     = 1'b0;
        nn_waddr  = SIW'(i_reg);
        nn_wdata  = min_reg;
        nn_raddr  = SIW'(j_reg);
        sq_start  = 1'b0;

        case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    pts_we   = (int'(cnt_reg) < MAX_POINTS);
                    cnt_next = total_new;
                    if (s_tlast) begin
                        // start a new set after every final point
                        cnt_next     = '0;
                        n_next       = SW'(sel_cnt_reg);
                        total_next   = total_new;
                        outn_next    = total_new - CNTW'(sel_cnt_reg);
                        c_next       = '0;
                        i_next       = '0;
                        changed_next = 1'b0;
                        fin_next     = 1'b0;
                        if (bad) begin
                            out_idx_next   = '0;
                            out_last_next  = 1'b1;
                            out_err_next   = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_INIT: begin
                // first n points go to the chosen list, the rest outside
                if (c_reg != total_reg) begin
                    if (int'(c_reg) < int'(n_reg)) begin
                        ch_we    = 1'b1;
                        ch_waddr = SIW'(c_reg);
                        ch_wdata = IW'(c_reg);
                    end else begin
                        os_we    = 1'b1;
                        os_waddr = IW'(c_ofs);
                        os_wdata = IW'(c_reg);
                    end
                    c_next = c_reg + CNTW'(1);
                end
            end
            S_PASS_I: begin
                ch_raddr = SIW'(i_reg);
            end
            S_I_PT: begin
                p_next    = ch_rdata;
                pts_raddr = ch_rdata;
            end
            S_I_REF: begin
                ref_next   = pts_rdata;
                min_next   = '1;
                j_next     = '0;
                phase_next = fin_reg ? PH_NN : PH_BEST;
            end
            S_N_CH: begin
                if (j_reg == n_reg) begin
                    case (phase_reg)
                        PH_BEST: begin
                            best_next  = min_reg;
                            found_next = 1'b0;
                            k_next     = '0;
                        end
                        PH_CAND: begin
                            // strictly greater keeps the earliest outside entry
                            if (min_reg > best_reg) begin
                                best_next   = min_reg;
                                pick_k_next = k_reg;
                                pick_v_next = q_reg;
                                found_next  = 1'b1;
                            end
                            k_next = k_reg + CNTW'(1);
                        end
                        PH_NN: begin
                            nn_we  = 1'b1;
                            i_next = i_reg + SW'(1);
                            if (i_reg == n_m1) begin
                                emitted_next = '0;
                                e_next       = '0;
                            end
                        end
                        default: begin
                            k_next = '0;
                        end
                    endcase
                end else if (j_reg == i_reg) begin
                    j_next = j_reg + SW'(1);
                end else begin
                    ch_raddr = SIW'(j_reg);
                end
            end
            S_N_PT: begin
                pts_raddr = ch_rdata;
            end
            S_N_DIST: begin
                sq_start = 1'b1;
            end
            S_N_WAIT: begin
                if (sq_done) begin
                    if (sq_dist < min_reg) begin
                        min_next = sq_dist;
                    end
                    j_next = j_reg + SW'(1);
                end
            end
            S_K_RD: begin
                os_raddr = IW'(k_reg);
            end
            S_K_PT: begin
                q_next    = os_rdata;
                pts_raddr = os_rdata;
            end
            S_K_REF: begin
                ref_next   = pts_rdata;
                min_next   = '1;
                j_next     = '0;
                phase_next = PH_CAND;
            end
            S_SWAP: begin
                if (found_reg) begin
                    ch_we = 1'b1;
                    os_we = 1'b1;
                end
                if (i_reg == n_m1) begin
                    i_next = '0;
                    if (found_reg || changed_reg) begin
                        changed_next = 1'b0;
                    end else begin
                        fin_next = 1'b1;
                    end
                end else begin
                    i_next       = i_reg + SW'(1);
                    changed_next = changed_reg || found_reg;
                end
            end
            S_SEL_INIT: begin
                j_next    = '0;
                have_next = 1'b0;
            end
            S_SC_RD: begin
                nn_raddr = SIW'(j_reg);
            end
            S_SC_CMP: begin
                // strictly greater keeps ties in their earlier position
                if (!emitted_reg[SIW'(j_reg)] && (!have_reg || nn_rdata > bmax_reg)) begin
                    bmax_next = nn_rdata;
                    bj_next   = j_reg;
                    have_next = 1'b1;
                end
                j_next = j_reg + SW'(1);
            end
            S_OUT_RD: begin
                ch_raddr = SIW'(bj_reg);
                emitted_next[SIW'(bj_reg)] = 1'b1;
            end
            S_OUT_LD: begin
                out_idx_next   = INDEX_OUT_W'(ch_rdata);
                out_last_next  = (e_reg == n_m1);
                out_err_next   = 1'b0;
                out_valid_next = 1'b1;
            end
            S_OUT_WAIT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    e_next         = e_reg + SW'(1);
                end
            end
            default: begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            phase_reg     <= PH_BEST;
            sel_cnt_reg   <= SEL_COUNT_RST;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            changed_reg   <= 1'b0;
            found_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            have_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sel_cnt_reg   <= sel_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            changed_reg   <= changed_next;
            found_reg     <= found_next;
            fin_reg       <= fin_next;
            have_reg      <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg    <= total_next;
        outn_reg     <= outn_next;
        c_reg        <= c_next;
        k_reg        <= k_next;
        pick_k_reg   <= pick_k_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        e_reg        <= e_next;
        bj_reg       <= bj_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        pick_v_reg   <= pick_v_next;
        ref_reg      <= ref_next;
        min_reg      <= min_next;
        best_reg     <= best_next;
        bmax_reg     <= bmax_next;
        emitted_reg  <= emitted_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

endmodule

@@ hdl/mmps_ram.sv @@
// ----------------------------------------------------------------------------
// mmps_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mmps_sqdist.sv @@
// ----------------------------------------------------------------------------
// mmps_sqdist
// Multi-cycle squared Euclidean distance, one square per cycle, saturating.
// ----------------------------------------------------------------------------
module mmps_sqdist #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [3*COORD_WIDTH-1:0]      pa,
    input  logic [3*COORD_WIDTH-1:0]      pb,
    output logic                          done,
    output logic [mmps_pkg::DIST_W-1:0]   dist_out
);
    import mmps_pkg::*;

    localparam int MW = COORD_WIDTH + 1;

    logic [MW-1:0]     mag_c   [3];
    logic [MW-1:0]     mag_reg [3];
    logic [1:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] sq_reg;
    logic [MW-1:0]     mag_sel;
    logic [DIST_W-1:0] mag64;
    logic [DIST_W-1:0] sq_c;
    logic [DIST_W:0]   sum_c;

    always_comb begin
        logic [MW-1:0] diff;
        for (int c = 0; c < 3; c++) begin
            diff = {pa[c*COORD_WIDTH + COORD_WIDTH-1], pa[c*COORD_WIDTH +: COORD_WIDTH]}
                 - {pb[c*COORD_WIDTH + COORD_WIDTH-1], pb[c*COORD_WIDTH +: COORD_WIDTH]};
            mag_c[c] = diff[MW-1] ? (~diff + MW'(1)) : diff;
        end
    end

    always_comb begin
        case (step_reg)
            2'd0:    mag_sel = mag_reg[0];
            2'd1:    mag_sel = mag_reg[1];
            2'd2:    mag_sel = mag_reg[2];
            default: mag_sel = '0;
        endcase
        mag64 = DIST_W'(mag_sel);
        // magnitudes above 32 bits saturate the square
        sq_c  = (|mag64[DIST_W-1:32]) ? '1 : (mag64[31:0] * mag64[31:0]);
        sum_c = {1'b0, acc_reg} + {1'b0, sq_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag_c;
            acc_reg <= '0;
            sq_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg <= sum_c[DIST_W] ? '1 : sum_c[DIST_W-1:0];
            sq_reg  <= sq_c;
        end
    end

    assign done     = done_reg;
    assign dist_out = acc_reg;

endmodule

@@ hdl/mmps_checker.sv @@
// ----------------------------------------------------------------------------
// mmps_checker
// Port-level checks for the max-min point subset selector.
// ----------------------------------------------------------------------------
module mmps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // error result closes the run
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 8'd0)
        else $error("error result with nonzero index");

    // no new points while results are pending
    a_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready during readout");

endmodule

bind max_min_point_subset_select mmps_checker u_mmps_checker (.*);
